### rtl/core/slid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DROP_W   = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_PRINT  = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } slid_op_e;

  typedef struct packed {
    slid_op_e          op;
    logic [DATA_W-1:0] value;
  } slid_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              valid;
    logic              after_ins; // insert point is at or before this cell
    logic              after_del; // first matching entry is at or before this cell
  } slid_link_t;

endpackage

`default_nettype wire

### rtl/core/slid_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module slid_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire slid_pkg::slid_ctrl_t ctrl_i,
  input  wire slid_pkg::slid_link_t prev_i,
  input  wire slid_pkg::slid_link_t next_i,
  input  wire logic [slid_pkg::DATA_W-1:0] head_i,
  output slid_pkg::slid_link_t      link_o
);

  logic [slid_pkg::DATA_W-1:0] val_q, val_d;
  logic                        valid_q, valid_d;
  logic                        greater;
  logic                        match;
  logic                        tail;

  assign greater = $signed(val_q) > $signed(ctrl_i.value);
  assign match   = valid_q && (val_q == ctrl_i.value);
  // last occupied cell: receives the head entry during a rotation
  assign tail    = valid_q && !next_i.valid;

  assign link_o.val       = val_q;
  assign link_o.valid     = valid_q;
  assign link_o.after_ins = !valid_q || greater;
  assign link_o.after_del = prev_i.after_del || match;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      slid_pkg::OP_INS: begin
        if (prev_i.after_ins) begin
          val_d   = prev_i.val;
          valid_d = prev_i.valid;
        end else if (link_o.after_ins) begin
          val_d   = ctrl_i.value;
          valid_d = 1'b1;
        end
      end
      slid_pkg::OP_DEL: begin
        // close the gap left by the first match
        if (link_o.after_del) begin
          val_d   = next_i.val;
          valid_d = next_i.valid;
        end
      end
      slid_pkg::OP_ROT: begin
        if (tail) begin
          val_d = head_i;
        end else if (valid_q) begin
          val_d = next_i.val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

### rtl/core/sorted_list_insert_delete_top.sv
// Insert: the whole chain shifts right past the insert point at once.
// Delete: equal entries are removed one per cycle by a left shift.
// Print: each item waits while the receiver stalls, and an empty list gives one item;
// the chain rotates by one cell per item and is back in order after the last one.
// Reset clears the cell valid bits, the entry count and the drop counter at once.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [1:0] cmd, [33:2] value, [39:34] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] entry, [39:32] drops
  output logic             m_axis_tlast,
  output logic             m_axis_tuser   // [0] empty_res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DEL   = 2'd1;
  localparam logic [1:0] ST_PRINT = 2'd2;

  localparam int unsigned CAP = slid_pkg::CAPACITY;
  localparam int unsigned CW  = slid_pkg::CNT_W;
  localparam int unsigned DW  = slid_pkg::DATA_W;
  localparam int unsigned DRW = slid_pkg::DROP_W;

  logic [1:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [DRW-1:0] drops_q, drops_d;
  logic [DW-1:0]  del_val_q, del_val_d;

  logic           out_valid_q, out_valid_d;
  logic [DW-1:0]  out_entry_q, out_entry_d;
  logic           out_last_q, out_last_d;
  logic           out_empty_q, out_empty_d;
  logic [DRW-1:0] out_drops_q, out_drops_d;

  logic          accept;
  logic [1:0]    in_cmd;
  logic [DW-1:0] in_value;
  logic          full;
  logic          out_free;
  logic          print_last;

  slid_pkg::slid_ctrl_t ctrl;
  slid_pkg::slid_link_t link [CAP];
  logic [CAP-1:0]       valid_vec;

  assign in_cmd        = s_axis_tdata[1:0];
  assign in_value      = s_axis_tdata[DW+1:2];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CW'(CAP));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign print_last    = ((idx_q + 1'b1) == count_q);

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    slid_pkg::slid_link_t prev_link, next_link;
    if (i == 0) begin : g_first
      assign prev_link = '0;
    end else begin : g_prev
      assign prev_link = link[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign next_link = '0;
    end else begin : g_next
      assign next_link = link[i+1];
    end
    slid_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_link),
      .next_i (next_link),
      .head_i (link[0].val),
      .link_o (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    drops_d     = drops_q;
    del_val_d   = del_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_entry_d = out_entry_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_drops_d = out_drops_q;
    ctrl.op     = slid_pkg::OP_HOLD;
    ctrl.value  = (state_q == ST_IDLE) ? in_value : del_val_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            slid_pkg::CMD_INSERT: begin
              if (full) begin
                if (drops_q != {DRW{1'b1}}) begin
                  drops_d = drops_q + 1'b1;
                end
              end else begin
                ctrl.op = slid_pkg::OP_INS;
                count_d = count_q + 1'b1;
              end
            end
            slid_pkg::CMD_DELETE: begin
              del_val_d = in_value;
              state_d   = ST_DEL;
            end
            slid_pkg::CMD_PRINT: begin
              idx_d   = '0;
              state_d = ST_PRINT;
            end
            default: ;
          endcase
        end
      end
      ST_DEL: begin
        // the last cell sees whether any cell still matches
        if (link[CAP-1].after_del) begin
          ctrl.op = slid_pkg::OP_DEL;
          count_d = count_q - 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PRINT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_drops_d = drops_q;
          if (count_q == '0) begin
            out_entry_d = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            ctrl.op     = slid_pkg::OP_ROT;
            out_entry_d = link[0].val;
            out_last_d  = print_last;
            out_empty_d = 1'b0;
            idx_d       = idx_q + 1'b1;
            if (print_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      drops_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      drops_q     <= drops_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    del_val_q   <= del_val_d;
    out_entry_q <= out_entry_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_drops_q <= out_drops_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_drops_q, out_entry_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAP))
    else $error("entry count above capacity");

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("occupied cells disagree with entry count");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty print item not marked last");

  a_print_rotates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == slid_pkg::OP_ROT) |-> (state_q == ST_PRINT && out_free))
    else $error("chain rotated without an item delivered");

endmodule

`default_nettype wire

### test/sorted_list_insert_delete_checker.sv
`timescale 1ns / 1ps

module sorted_list_insert_delete_checker
  import slid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [39:0] s_tdata_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [39:0] m_tdata_i,
  input  wire logic        m_tlast_i,
  input  wire logic        m_tuser_i,
  output int               pending_o,
  output int               mismatches_o
);

  typedef struct packed {
    logic [DATA_W-1:0] entry;
    logic              last;
    logic              empty;
    logic [DROP_W-1:0] drops;
  } list_entry_t;

  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int unsigned              list_len;
  logic [DROP_W-1:0]        drop_tally;
  list_entry_t              print_q [$];
  int                       mismatches = 0;

  task automatic apply_list_cmd(input logic [1:0] cmd, input logic signed [DATA_W-1:0] v);
    int unsigned pos;
    int unsigned wr;
    pos = list_len;
    wr  = 0;
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          // full: drop the item, count saturates
          if (drop_tally != '1) drop_tally++;
        end else begin
          for (int i = 0; i < list_len; i++)
            if (list_vals[i] > v && pos == list_len) pos = i;
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = v;
          list_len++;
        end
      end
      CMD_DELETE: begin
        for (int i = 0; i < list_len; i++)
          if (list_vals[i] != v) begin
            list_vals[wr] = list_vals[i];
            wr++;
          end
        list_len = wr;
      end
      CMD_PRINT: begin
        if (list_len == 0) print_q.push_back('{'0, 1'b1, 1'b1, drop_tally});
        else
          for (int i = 0; i < list_len; i++)
            print_q.push_back('{list_vals[i], (i + 1 == list_len), 1'b0, drop_tally});
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_entry_t got;
    list_entry_t want;
    if (!rst_ni) begin
      list_len     = 0;
      drop_tally   = '0;
      print_q.delete();
      pending_o    <= 0;
      mismatches_o <= mismatches;
    end else begin
      // results first: an item accepted at this edge cannot have produced one yet
      if (m_tvalid_i && m_tready_i) begin
        got = '{m_tdata_i[31:0], m_tlast_i, m_tuser_i, m_tdata_i[39:32]};
        if (print_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item: entry %0d last %0b empty %0b drops %0d",
                     $realtime, $signed(got.entry), got.last, got.empty, got.drops);
        end else begin
          want = print_q.pop_front();
          if (got.entry !== want.entry || got.last !== want.last ||
              got.empty !== want.empty || got.drops !== want.drops) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected entry %0d last %0b empty %0b drops %0d", $realtime,
                       $signed(want.entry), want.last, want.empty, want.drops);
              $display("%0t: actual   entry %0d last %0b empty %0b drops %0d", $realtime,
                       $signed(got.entry), got.last, got.empty, got.drops);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) apply_list_cmd(s_tdata_i[1:0], s_tdata_i[33:2]);
      pending_o    <= print_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

### test/sorted_list_insert_delete_top_tb.sv
`timescale 1ns / 1ps

module sorted_list_insert_delete_top_tb;
  import slid_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned POOL_N = 6;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int          pending;
  int          mismatches;
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  logic [31:0] pool [POOL_N];

  sorted_list_insert_delete_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  sorted_list_insert_delete_checker list_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Leaves tvalid high after acceptance; the caller drops it when the stream ends.
  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v, cmd};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return pool[$urandom_range(0, POOL_N - 1)];
    if (roll < 75) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // Receiver: short random stalls, one long hold-off on request.
  initial begin : sink
    int  stall_left;
    int  hold_left;
    bit  hold_used;
    stall_left = 0;
    hold_left  = 0;
    hold_used  = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned roll;
    logic [1:0]  cmd;
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    for (int i = 0; i < POOL_N; i++) pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty print, extremes, equal values, absent delete, unused code
    send_cmd(CMD_PRINT,  32'hdead_beef);
    send_cmd(CMD_INSERT, 32'h7fff_ffff);
    send_cmd(CMD_INSERT, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'h0);
    send_cmd(CMD_INSERT, 32'h0);
    send_cmd(CMD_INSERT, 32'hffff_ffff);
    send_cmd(CMD_PRINT,  32'h0);
    send_cmd(CMD_DELETE, 32'd5);
    send_cmd(CMD_DELETE, 32'h0);
    send_cmd(CMD_PRINT,  32'hffff_ffff);
    send_cmd(CMD_UNUSED, 32'hffff_ffff);
    send_cmd(CMD_PRINT,  32'h0);
    send_cmd(CMD_DELETE, 32'h7fff_ffff);
    send_cmd(CMD_DELETE, 32'h8000_0000);
    send_cmd(CMD_DELETE, 32'hffff_ffff);
    send_cmd(CMD_PRINT,  32'h0);
    send_cmd(CMD_INSERT, 32'd7);
    send_cmd(CMD_INSERT, 32'd7);
    send_cmd(CMD_INSERT, 32'd3);
    send_cmd(CMD_PRINT,  32'h0);
    send_cmd(CMD_DELETE, 32'd7);
    send_cmd(CMD_PRINT,  32'h0);

    // fill the list and drop a few inserts once it is full
    for (int k = 0; k < 36; k++) begin
      send_cmd(CMD_INSERT, pool[$urandom_range(0, POOL_N - 1)]);
    end
    send_cmd(CMD_PRINT, $urandom);

    for (int k = 0; k < 110; k++) begin
      if (k == 20) hold_go <= 1'b1;
      if (k == 90) calm = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 45)      cmd = CMD_INSERT;
      else if (roll < 70) cmd = CMD_DELETE;
      else if (roll < 94) cmd = CMD_PRINT;
      else                cmd = CMD_UNUSED;
      send_cmd(cmd, pick_value());
    end
    send_cmd(CMD_PRINT, $urandom);
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
